/* sv/sqtc_pkg.sv */
package sqtc_pkg;

  localparam int QW     = 16;            // quaternion and scale fields
  localparam int PW     = 2 * QW;        // quaternion product
  localparam int MW     = 35;            // rotation term, Q.28
  localparam int RW     = MW + QW - 24;  // scaled rotation element, Q.16
  localparam int TW     = 32;            // translation, Q24.8
  localparam int OW     = 48;            // output element, Q32.16
  localparam int IN_DW  = 208;
  localparam int OUT_DW = 200;
  localparam int CIW    = 3;
  localparam int CDW    = 64;

  localparam logic signed [MW-1:0] ONE_Q28 = MW'(64'sd268435456);
  localparam logic signed [OW-1:0] ONE_Q16 = OW'(64'sd65536);

  typedef logic signed [QW-1:0] q_t;
  typedef q_t [3:0]             quat_t;   // x lowest, w highest
  typedef q_t [2:0]             svec_t;   // x lowest
  typedef logic signed [RW-1:0] rel_t;
  typedef rel_t [2:0][2:0]      rmat_t;   // [row][col]
  typedef logic signed [TW-1:0] tr_t;
  typedef tr_t [2:0]            tvec_t;

  typedef struct packed {
    logic  valid;
    rmat_t rot;
    tvec_t tr;
  } xform_t;

  typedef enum logic [CIW-1:0] {
    CFG_ROT   = 3'd0,
    CFG_SCALE = 3'd1,
    CFG_OFF_X = 3'd2,
    CFG_OFF_Y = 3'd3,
    CFG_OFF_Z = 3'd4
  } cfg_idx_t;

endpackage

/* sv/sqtc_rot.sv */
module sqtc_rot (
  input  logic           clk,
  input  logic           en,
  input  sqtc_pkg::quat_t quat,
  input  sqtc_pkg::svec_t scl,
  output sqtc_pkg::rmat_t rot
);
  import sqtc_pkg::*;

  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  svec_t s1_r, s2_r;
  logic signed [MW-1:0] t_r   [3][3];
  logic signed [MW-1:0] t_nxt [3][3];
  logic signed [MW+QW-1:0] m  [3][3];
  rmat_t rot_r, rot_nxt;

  function automatic logic signed [MW-1:0] dbl(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
    logic signed [MW-1:0] s;
    s = MW'(a) + MW'(b);
    return s <<< 1;
  endfunction

  function automatic logic signed [MW-1:0] dbd(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
    logic signed [MW-1:0] s;
    s = MW'(a) - MW'(b);
    return s <<< 1;
  endfunction

  // stage 1: quaternion products
  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= quat[0] * quat[0];
      yy_r <= quat[1] * quat[1];
      zz_r <= quat[2] * quat[2];
      xy_r <= quat[0] * quat[1];
      xz_r <= quat[0] * quat[2];
      yz_r <= quat[1] * quat[2];
      wx_r <= quat[3] * quat[0];
      wy_r <= quat[3] * quat[1];
      wz_r <= quat[3] * quat[2];
      s1_r <= scl;
    end
  end

  // stage 2: rotation terms in Q.28
  always_comb begin
    t_nxt[0][0] = ONE_Q28 - dbl(yy_r, zz_r);
    t_nxt[0][1] = dbl(xy_r, wz_r);
    t_nxt[0][2] = dbd(xz_r, wy_r);
    t_nxt[1][0] = dbd(xy_r, wz_r);
    t_nxt[1][1] = ONE_Q28 - dbl(xx_r, zz_r);
    t_nxt[1][2] = dbl(yz_r, wx_r);
    t_nxt[2][0] = dbl(xz_r, wy_r);
    t_nxt[2][1] = dbd(yz_r, wx_r);
    t_nxt[2][2] = ONE_Q28 - dbl(xx_r, yy_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_nxt;
      s2_r <= s1_r;
    end
  end

  // stage 3: scale each row, floor to Q.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j]       = t_r[i][j] * s2_r[i];
        rot_nxt[i][j] = m[i][j][MW+QW-1:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot = rot_r;

endmodule

/* sv/sqtc_row.sv */
module sqtc_row (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sqtc_pkg::xform_t             item,
  input  sqtc_pkg::rmat_t              prot,
  input  sqtc_pkg::tvec_t              poff,
  output logic                         take,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sqtc_pkg::OUT_DW-1:0]  out_tdata,
  output logic                         out_tlast
);
  import sqtc_pkg::*;

  localparam int EW = TW + RW;
  localparam int AW = EW + 2;

  logic adv;
  logic d_valid_r, e_valid_r, f_valid_r, out_valid_r;
  logic [1:0] d_row_r, e_row_r, f_row_r, out_row_r;
  rmat_t d_rot_r;
  tvec_t d_tr_r;
  logic [1:0] rsel;
  logic signed [TW-1:0] a [3];
  logic signed [EW-1:0] e_prod_r [3][3];
  logic signed [EW-1:0] e_prod_nxt [3][3];
  logic signed [AW-1:0] f_acc_r [3];
  logic signed [AW-1:0] f_acc_nxt [3];
  logic signed [AW:0]   sh [3];
  logic signed [AW:0]   off [3];
  logic signed [AW:0]   v [3];
  logic signed [OW-1:0] out_el_r [3];
  logic signed [OW-1:0] out_el_nxt [3];
  logic signed [OW-1:0] el_d;

  assign adv  = !out_valid_r || out_tready;
  assign take = adv && (!d_valid_r || d_row_r == 2'd3);

  // hold item for four row issues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      d_row_r   <= 2'd0;
    end else if (take) begin
      d_valid_r <= item.valid;
      d_row_r   <= 2'd0;
    end else if (adv) begin
      d_row_r <= d_row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      d_rot_r <= item.rot;
      d_tr_r  <= item.tr;
    end
  end

  assign rsel = (d_row_r == 2'd3) ? 2'd0 : d_row_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a[k] = (d_row_r == 2'd3) ? d_tr_r[k] : TW'(d_rot_r[rsel][k]);
      for (int j = 0; j < 3; j++) begin
        e_prod_nxt[k][j] = a[k] * prot[k][j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      f_acc_nxt[j] = AW'(e_prod_r[0][j]) + AW'(e_prod_r[1][j]) + AW'(e_prod_r[2][j]);
    end
  end

  // shift to Q.16, add parent offset on the translation row, saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      off[j] = poff[j];
      off[j] = off[j] <<< 8;
      sh[j]  = f_acc_r[j];
      if (f_row_r == 2'd3) begin
        sh[j] = sh[j] >>> 8;
        v[j]  = sh[j] + off[j];
      end else begin
        sh[j] = sh[j] >>> 16;
        v[j]  = sh[j];
      end
      if (v[j][AW:OW-1] == '0 || v[j][AW:OW-1] == '1) begin
        out_el_nxt[j] = v[j][OW-1:0];
      end else if (v[j][AW]) begin
        out_el_nxt[j] = {1'b1, {(OW-1){1'b0}}};
      end else begin
        out_el_nxt[j] = {1'b0, {(OW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r   <= d_valid_r;
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod_r  <= e_prod_nxt;
      e_row_r   <= d_row_r;
      f_acc_r   <= f_acc_nxt;
      f_row_r   <= e_row_r;
      out_el_r  <= out_el_nxt;
      out_row_r <= f_row_r;
    end
  end

  assign el_d       = (out_row_r == 2'd3) ? ONE_Q16 : '0;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = (out_row_r == 2'd3);
  assign out_tdata  = {6'd0, el_d, out_el_r[2], out_el_r[1], out_el_r[0], out_row_r};

endmodule

/* sv/scaled_quaternion_transform_compose.sv */
// Scaled quaternion transform composer.
// Input stream (in_*): one word per local transform (quaternion Q1.14,
// translation Q24.8, per-axis scale Q4.12). The word is turned into a 4x4
// matrix and multiplied by the parent matrix built from the cfg_* registers.
// Output stream (out_*): four words per input, product rows 0..3 in order,
// tlast on row 3. Elements are Q32.16, floored, saturated to 48 bits.
// Pipeline: three stages build the local rotation block, a row stage holds
// the transform and issues one row per cycle unless out_tready stalls, then
// multiply, sum and saturate stages. Throughput is set by the single row
// issue port: a new word is taken only when the row stage is empty or
// issuing row 3, so under load in_tready is low while rows 0..2 issue.
// The parent matrix is rebuilt continuously from the registers; write them
// only while no word is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads the parent
// registers with identity rotation, unit scale and zero offset.
// A stall on out_tready freezes the whole pipeline; nothing is dropped or
// repeated, and in_tready stays low until the row stage frees.
module scaled_quaternion_transform_compose (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // quat_x, quat_y, quat_z, quat_w, move_x, move_y, move_z,
  // stretch_x, stretch_y, stretch_z
  input  logic [sqtc_pkg::IN_DW-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // row_index, elem_a, elem_b, elem_c, elem_d, zero pad
  output logic [sqtc_pkg::OUT_DW-1:0]    out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [sqtc_pkg::CIW-1:0]       cfg_index,
  input  logic [sqtc_pkg::CDW-1:0]       cfg_data
);
  import sqtc_pkg::*;

  logic [63:0] p_rot_r;
  logic [47:0] p_scale_r;
  tvec_t p_off_r;
  rmat_t p_mat, l_mat;
  logic take;
  logic v1_r, v2_r, v3_r;
  tvec_t tr1_r, tr2_r, tr3_r;
  xform_t item;

  // parent registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_rot_r   <= 64'h4000_0000_0000_0000;
      p_scale_r <= 48'h1000_1000_1000;
      p_off_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROT:   p_rot_r    <= cfg_data;
        CFG_SCALE: p_scale_r  <= cfg_data[47:0];
        CFG_OFF_X: p_off_r[0] <= cfg_data[TW-1:0];
        CFG_OFF_Y: p_off_r[1] <= cfg_data[TW-1:0];
        CFG_OFF_Z: p_off_r[2] <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // parent matrix, free running
  sqtc_rot u_prot (
    .clk  (clk),
    .en   (1'b1),
    .quat (quat_t'(p_rot_r)),
    .scl  (svec_t'(p_scale_r)),
    .rot  (p_mat)
  );

  // local matrix, advances with the input side
  sqtc_rot u_lrot (
    .clk  (clk),
    .en   (take),
    .quat (quat_t'(in_tdata[63:0])),
    .scl  (svec_t'(in_tdata[207:160])),
    .rot  (l_mat)
  );

  assign in_tready = take;

  // valid and translation travel beside the rotation stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (take) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tr1_r <= tvec_t'(in_tdata[159:64]);
      tr2_r <= tr1_r;
      tr3_r <= tr2_r;
    end
  end

  assign item.valid = v3_r;
  assign item.rot   = l_mat;
  assign item.tr    = tr3_r;

  sqtc_row u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .prot       (p_mat),
    .poff       (p_off_r),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
